/* sv/poisson_disc_candidate_checker_assert.svh */
// Assertion macros shared by the Poisson disc checker RTL.
`ifndef POISSON_DISC_CANDIDATE_CHECKER_ASSERT_SVH
`define POISSON_DISC_CANDIDATE_CHECKER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define PDCC_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("pdcc assertion failed");

// Condition holds in the cycle after the trigger.
`define PDCC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pdcc assertion failed");

`endif

/* sv/pdcc_pkg.sv */
// Types and codes of the Poisson disc candidate checker.
package pdcc_pkg;

  localparam logic FUNC_SEED  = 1'b0;
  localparam logic FUNC_TRIAL = 1'b1;

  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_BOUNDS   = 3'd1;
  localparam logic [2:0] ST_OCCUPIED = 3'd2;
  localparam logic [2:0] ST_CLOSE    = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT = 3'd4;
  localparam logic [2:0] ST_SEEDED   = 3'd5;

  localparam logic [1:0] CFG_MIN_DIST  = 2'd0;
  localparam logic [1:0] CFG_CELL_SIZE = 2'd1;
  localparam logic [1:0] CFG_COLS      = 2'd2;
  localparam logic [1:0] CFG_ROWS      = 2'd3;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = 4;

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_LOAD  = 17'h00004,
    S_DIVX  = 17'h00008,
    S_DIVY  = 17'h00010,
    S_IDX   = 17'h00020,
    S_CELL  = 17'h00040,
    S_CHK   = 17'h00080,
    S_NADDR = 17'h00100,
    S_NRD   = 17'h00200,
    S_NDX   = 17'h00400,
    S_NDY   = 17'h00800,
    S_NCMP  = 17'h01000,
    S_ACC   = 17'h02000,
    S_FIN   = 17'h04000,
    S_RET   = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

endpackage

/* sv/poisson_disc_candidate_checker.sv */
// Poisson disc candidate checker: background grid, active list and trial sequencer.
// A trial ends early on a bad slot, off the plane, beyond the grid or on an occupied
// cell; else it probes the 25 neighbor cells, and a slot that retires adds the S_RET state.
// Divider, multiplier and cell read port are shared.
// A seed first sweeps the whole grid empty, then places its point unless it lies off the grid.
// Reset: synchronous; sweeps the grid with in_stall high.
module poisson_disc_candidate_checker
  import pdcc_pkg::*;
#(
  parameter int MAX_COLS      = 256,
  parameter int MAX_ROWS      = 128,
  parameter int NEIGHBOR_SPAN = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [15:0]        seed_x,
  input  logic [15:0]        seed_y,
  input  logic [14:0]        slot,
  input  logic signed [14:0] offset_x,
  input  logic signed [14:0] offset_y,
  input  logic               last_trial,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [15:0]        point_x,
  output logic [15:0]        point_y,
  output logic [14:0]        cell_index,
  output logic [15:0]        active_count,
  output logic               retired
);

  localparam int GRID_CAP = MAX_COLS * MAX_ROWS;
  localparam int AW       = $clog2(GRID_CAP);
  localparam int TW       = AW + 1;
  localparam int NB_N     = 2 * NEIGHBOR_SPAN + 1;
  localparam int NW       = $clog2(NB_N);
  localparam int COLS_LIM = MAX_COLS > 256 ? 256 : MAX_COLS;
  localparam int ROWS_LIM = MAX_ROWS > 128 ? 128 : MAX_ROWS;
  localparam logic [NW-1:0] NB_LAST  = NW'(NB_N - 1);
  localparam logic [AW-1:0] CAP_LAST = AW'(GRID_CAP - 1);

  // Configuration registers
  logic [13:0] min_distance;
  logic [15:0] cell_size;
  logic [8:0]  grid_cols;
  logic [7:0]  grid_rows;

  // Effective geometry: clamp columns and rows, treat a zero cell size as one
  logic [15:0] cs_eff;
  logic [8:0]  cols_eff;
  logic [7:0]  rows_eff;

  always_comb begin
    cs_eff = (cell_size == 16'd0) ? 16'd1 : cell_size;
    if (grid_cols == 9'd0) begin
      cols_eff = 9'd1;
    end else if (32'(grid_cols) > COLS_LIM) begin
      cols_eff = 9'(COLS_LIM);
    end else begin
      cols_eff = grid_cols;
    end
    if (grid_rows == 8'd0) begin
      rows_eff = 8'd1;
    end else if (32'(grid_rows) > ROWS_LIM) begin
      rows_eff = 8'(ROWS_LIM);
    end else begin
      rows_eff = grid_rows;
    end
  end

  // Sequencer and datapath registers
  state_t         state;
  logic [AW-1:0]  clr_addr;
  logic           seeding;
  logic [TW-1:0]  active_total;
  logic           found_any;
  logic [AW-1:0]  slot_q;
  logic           last_q;
  logic [14:0]    off_xq;
  logic [14:0]    off_yq;
  logic [15:0]    cx;
  logic [15:0]    cy;
  logic [15:0]    col;
  logic [15:0]    row;
  logic [AW-1:0]  cidx;
  logic [2:0]     res_status;
  logic           res_ret;
  logic [27:0]    lim;
  logic [33:0]    acc;
  logic [NW-1:0]  ni;
  logic [NW-1:0]  nj;
  logic [AW-1:0]  nb_col;

  // Shared divider: restoring, one quotient bit per cycle
  logic [15:0]       quo;
  logic [16:0]       rem;
  logic [DIV_CW-1:0] div_cnt;
  logic [16:0]       rem_sh;
  logic [17:0]       rem_diff;
  logic [16:0]       rem_next;
  logic [15:0]       quo_next;

  always_comb begin
    rem_sh   = {rem[15:0], quo[15]};
    rem_diff = {1'b0, rem_sh} - {2'b00, cs_eff};
    rem_next = rem_diff[17] ? rem_sh : rem_diff[16:0];
    quo_next = {quo[14:0], ~rem_diff[17]};
  end

  // Shared multiplier: registered product, one use per cycle
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] mul_q;

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // Grid memory: {valid, y, x} per cell
  logic [32:0]   cell_mem [GRID_CAP];
  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  logic [32:0]   cell_wdata;
  logic          cell_re;
  logic [AW-1:0] cell_raddr;
  logic [32:0]   cell_rdata;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata <= cell_mem[cell_raddr];
    end
  end

  // Active list memory: {y, x}
  logic [31:0]   act_mem [GRID_CAP];
  logic          act_we;
  logic [AW-1:0] act_waddr;
  logic [31:0]   act_wdata;
  logic          act_re;
  logic [AW-1:0] act_raddr;
  logic [31:0]   act_rdata;

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    if (act_re) begin
      act_rdata <= act_mem[act_raddr];
    end
  end

  // Candidate forming, neighbor coordinates and distance terms
  logic [31:0]        base;
  logic signed [17:0] cand_x;
  logic signed [17:0] cand_y;
  logic signed [17:0] nc;
  logic signed [17:0] nr;
  logic               nb_in;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic [34:0]        d2;
  logic               nb_done;
  logic [AW-1:0]      cell_idx;
  logic               in_take;
  logic               out_free;

  always_comb begin
    base    = seeding ? {cy, cx} : act_rdata;
    cand_x  = $signed({2'b00, base[15:0]}) + $signed({{3{off_xq[14]}}, off_xq});
    cand_y  = $signed({2'b00, base[31:16]}) + $signed({{3{off_yq[14]}}, off_yq});
    nc      = $signed({2'b00, col}) + $signed(18'(ni)) - $signed(18'(NEIGHBOR_SPAN));
    nr      = $signed({2'b00, row}) + $signed(18'(nj)) - $signed(18'(NEIGHBOR_SPAN));
    nb_in   = !nc[17] && (nc[16:0] < 17'(cols_eff)) &&
              !nr[17] && (nr[16:0] < 17'(rows_eff));
    dx      = $signed({2'b00, cx}) - $signed({2'b00, cell_rdata[15:0]});
    dy      = $signed({2'b00, cy}) - $signed({2'b00, cell_rdata[31:16]});
    d2      = {1'b0, acc} + {1'b0, mul_q[33:0]};
    nb_done = (ni == NB_LAST) && (nj == NB_LAST);
    cell_idx = AW'(mul_q) + AW'(col);
    in_take  = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
  end

  // Memory ports and multiplier operands, steered by the sequencer
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_idx;
    cell_wdata = {1'b1, cy, cx};
    cell_re    = 1'b0;
    cell_raddr = cell_idx;
    act_we     = 1'b0;
    act_waddr  = AW'(active_total);
    act_wdata  = {cy, cx};
    act_re     = 1'b0;
    act_raddr  = AW'(slot);
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr;
        cell_wdata = '0;
      end
      S_IDLE: begin
        act_re = in_take;
      end
      S_IDX: begin
        mul_a = $signed({2'b00, row});
        mul_b = $signed({9'd0, cols_eff});
      end
      S_CELL: begin
        // Seed: place the point; trial: probe the candidate's own cell
        cell_we   = seeding && (row < {8'd0, rows_eff}) && (col < {7'd0, cols_eff});
        act_we    = cell_we;
        act_waddr = '0;
        cell_re   = !seeding;
        mul_a     = $signed({4'd0, min_distance});
        mul_b     = $signed({4'd0, min_distance});
      end
      S_NADDR: begin
        mul_a = nr;
        mul_b = $signed({9'd0, cols_eff});
      end
      S_NRD: begin
        cell_re    = 1'b1;
        cell_raddr = AW'(mul_q) + nb_col;
      end
      S_NDX: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_NDY: begin
        mul_a = dy;
        mul_b = dy;
      end
      S_ACC: begin
        cell_we    = 1'b1;
        cell_waddr = cidx;
        act_we     = 32'(active_total) < GRID_CAP;
      end
      S_FIN: begin
        act_re    = 1'b1;
        act_raddr = AW'(active_total - TW'(1));
      end
      S_RET: begin
        act_we    = 1'b1;
        act_waddr = slot_q;
        act_wdata = act_rdata;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      seeding      <= 1'b0;
      active_total <= '0;
      found_any    <= 1'b0;
      out_valid    <= 1'b0;
      min_distance <= 14'd320;
      cell_size    <= 16'd226;
      grid_cols    <= 9'd135;
      grid_rows    <= 8'd76;
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_MIN_DIST:  min_distance <= wr_data[13:0];
          CFG_CELL_SIZE: cell_size    <= wr_data;
          CFG_COLS:      grid_cols    <= wr_data[8:0];
          CFG_ROWS:      grid_rows    <= wr_data[7:0];
          default: begin
          end
        endcase
      end

      // Drop the output once taken; a result waiting in S_DONE reloads it instead
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          // Sweep every cell empty, then place the seed if one is waiting
          if (clr_addr == CAP_LAST) begin
            clr_addr <= '0;
            state    <= seeding ? S_LOAD : S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_take) begin
            res_ret <= 1'b0;
            slot_q  <= AW'(slot);
            last_q  <= last_trial;
            if (func == FUNC_SEED) begin
              seeding      <= 1'b1;
              cx           <= seed_x;
              cy           <= seed_y;
              off_xq       <= '0;
              off_yq       <= '0;
              active_total <= '0;
              found_any    <= 1'b0;
              state        <= S_CLEAR;
            end else begin
              seeding <= 1'b0;
              off_xq  <= offset_x;
              off_yq  <= offset_y;
              if (32'(slot) >= 32'(active_total) || 32'(slot) >= GRID_CAP) begin
                res_status <= ST_BAD_SLOT;
                state      <= S_DONE;
              end else begin
                state <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          // Form the candidate; reject anything off the 16-bit plane
          cx      <= cand_x[15:0];
          cy      <= cand_y[15:0];
          quo     <= cand_x[15:0];
          rem     <= '0;
          div_cnt <= '0;
          if (cand_x[17] || cand_x[16] || cand_y[17] || cand_y[16]) begin
            res_status <= ST_BOUNDS;
            state      <= S_FIN;
          end else begin
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_cnt == DIV_CW'(DIV_STEPS - 1)) begin
            col     <= quo_next;
            quo     <= cy;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIVY;
          end else begin
            rem     <= rem_next;
            quo     <= quo_next;
            div_cnt <= div_cnt + DIV_CW'(1);
          end
        end
        S_DIVY: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt + DIV_CW'(1);
          if (div_cnt == DIV_CW'(DIV_STEPS - 1)) begin
            row   <= quo_next;
            state <= S_IDX;
          end
        end
        S_IDX: begin
          if (col >= {7'd0, cols_eff} || row >= {8'd0, rows_eff}) begin
            res_status <= ST_BOUNDS;
            state      <= seeding ? S_DONE : S_FIN;
          end else begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          cidx <= cell_idx;
          if (seeding) begin
            active_total <= TW'(1);
            res_status   <= ST_SEEDED;
            state        <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          lim <= mul_q[27:0];
          ni  <= '0;
          nj  <= '0;
          if (cell_rdata[32]) begin
            res_status <= ST_OCCUPIED;
            state      <= S_FIN;
          end else begin
            state <= S_NADDR;
          end
        end
        S_NADDR, S_NDX, S_NCMP: begin
          if (state == S_NADDR && nb_in) begin
            nb_col <= AW'(nc);
            state  <= S_NRD;
          end else if (state == S_NDX && cell_rdata[32]) begin
            state <= S_NDY;
          end else if (state == S_NCMP && d2 <= 35'(lim)) begin
            res_status <= ST_CLOSE;
            state      <= S_FIN;
          end else if (nb_done) begin
            state <= S_ACC;
          end else begin
            // Advance to the next neighbor cell
            if (nj == NB_LAST) begin
              nj <= '0;
              ni <= ni + NW'(1);
            end else begin
              nj <= nj + NW'(1);
            end
            state <= S_NADDR;
          end
        end
        S_NRD: begin
          state <= S_NDX;
        end
        S_NDY: begin
          acc   <= mul_q[33:0];
          state <= S_NCMP;
        end
        S_ACC: begin
          if (32'(active_total) < GRID_CAP) begin
            active_total <= active_total + TW'(1);
          end
          found_any  <= 1'b1;
          res_status <= ST_ACCEPT;
          state      <= S_FIN;
        end
        S_FIN: begin
          // Retire the slot on its last trial if nothing was accepted since
          if (last_q && !found_any) begin
            state <= S_RET;
          end else begin
            if (last_q) begin
              found_any <= 1'b0;
            end
            state <= S_DONE;
          end
        end
        S_RET: begin
          active_total <= active_total - TW'(1);
          res_ret      <= 1'b1;
          found_any    <= 1'b0;
          state        <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            point_x      <= (res_status == ST_ACCEPT || res_status == ST_SEEDED) ? cx : '0;
            point_y      <= (res_status == ST_ACCEPT || res_status == ST_SEEDED) ? cy : '0;
            cell_index   <= (res_status == ST_ACCEPT || res_status == ST_SEEDED ||
                             res_status == ST_OCCUPIED || res_status == ST_CLOSE)
                            ? 15'(cidx) : '0;
            active_count <= 16'(active_total);
            retired      <= res_ret;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "poisson_disc_candidate_checker_assert.svh"

  `PDCC_ASSERT_SAME(a_total_cap, 1'b1, 32'(active_total) <= GRID_CAP)
  `PDCC_ASSERT_NEXT(a_busy_after_take, in_take, state != S_IDLE)
  `PDCC_ASSERT_NEXT(a_done_loads, (state == S_DONE) && out_free, out_valid)
  `PDCC_ASSERT_SAME(a_retire_status, out_valid && retired, status >= ST_BOUNDS && status <= ST_CLOSE)

endmodule

/* tb/poisson_disc_candidate_checker_tb_pkg.sv */
`timescale 1ns / 100ps
// Item and result types shared by the Poisson disc checker testbench.
package poisson_disc_candidate_checker_tb_pkg;

  typedef struct {
    logic        func;
    logic [15:0] seed_x;
    logic [15:0] seed_y;
    logic [14:0] slot;
    logic [14:0] offset_x;
    logic [14:0] offset_y;
    logic        last_trial;
  } trial_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [14:0] cell_index;
    logic [15:0] active_count;
    logic        retired;
  } disc_result_t;

endpackage

/* tb/tb_poisson_disc_candidate_checker.sv */
`timescale 1ns / 100ps
// Top level of the Poisson disc candidate checker testbench.
module tb_poisson_disc_candidate_checker;
  import pdcc_pkg::*;
  import poisson_disc_candidate_checker_tb_pkg::*;

  localparam int GRID_CAP   = 256 * 128;
  localparam int LATENCY    = 200;
  localparam int IDLE_LIMIT = 400000;

  logic        clk, rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;
  logic        in_valid, in_stall;
  logic        func;
  logic [15:0] seed_x, seed_y;
  logic [14:0] slot;
  logic signed [14:0] offset_x, offset_y;
  logic        last_trial;
  logic        out_valid, out_stall;
  logic [2:0]  status;
  logic [15:0] point_x, point_y;
  logic [14:0] cell_index;
  logic [15:0] active_count;
  logic        retired;

  poisson_disc_candidate_checker uut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .seed_x(seed_x), .seed_y(seed_y), .slot(slot),
    .offset_x(offset_x), .offset_y(offset_y), .last_trial(last_trial),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .point_x(point_x), .point_y(point_y),
    .cell_index(cell_index), .active_count(active_count), .retired(retired)
  );

  // Shadow copy of the grid, the active list and the registers.
  bit          grid_full [GRID_CAP];
  logic [31:0] grid_point [GRID_CAP];
  logic [31:0] active_pts [GRID_CAP];
  int          active_total;
  bit          slot_found;
  int          min_dist, cell_sz, cols_reg, rows_reg;

  disc_result_t pending_results[$];
  int  mismatches;
  int  seeds_sent;
  bit  tx_gaps, rx_gaps;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_cols();
    return cols_reg < 1 ? 1 : (cols_reg > 256 ? 256 : cols_reg);
  endfunction

  function automatic int eff_rows();
    return rows_reg < 1 ? 1 : (rows_reg > 128 ? 128 : rows_reg);
  endfunction

  // Map a point to its cell; zero when it lands outside the grid in use.
  function automatic bit map_to_cell(int x, int y, output int col, output int row);
    int cs;
    cs  = cell_sz == 0 ? 1 : cell_sz;
    col = 0;
    row = 0;
    if (x < 0 || y < 0 || x > 65535 || y > 65535) return 1'b0;
    col = x / cs;
    row = y / cs;
    return col < eff_cols() && row < eff_rows();
  endfunction

  function automatic bit near_neighbor(int x, int y, int col, int row);
    longint lim, dx, dy;
    int nc, nr, idx;
    lim = longint'(min_dist) * longint'(min_dist);
    for (int di = -2; di <= 2; di++) begin
      for (int dj = -2; dj <= 2; dj++) begin
        nc = col + di;
        nr = row + dj;
        if (nc < 0 || nc >= eff_cols() || nr < 0 || nr >= eff_rows()) continue;
        idx = nc + nr * eff_cols();
        if (!grid_full[idx]) continue;
        dx = longint'(x - int'(grid_point[idx][15:0]));
        dy = longint'(y - int'(grid_point[idx][31:16]));
        if (dx * dx + dy * dy <= lim) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the shadow state by one item and queue the result it causes.
  task automatic predict_result(input trial_item_t it);
    disc_result_t r;
    int x, y, col, row, idx;
    logic [31:0] a;
    r = '{status: ST_BOUNDS, point_x: 0, point_y: 0, cell_index: 0,
          active_count: 0, retired: 0};
    if (it.func == FUNC_SEED) begin
      foreach (grid_full[i]) grid_full[i] = 1'b0;
      active_total = 0;
      slot_found = 1'b0;
      x = int'(it.seed_x);
      y = int'(it.seed_y);
      if (map_to_cell(x, y, col, row)) begin
        idx = col + row * eff_cols();
        grid_full[idx] = 1'b1;
        grid_point[idx] = {it.seed_y, it.seed_x};
        active_pts[0] = grid_point[idx];
        active_total = 1;
        r.status = ST_SEEDED;
        r.point_x = it.seed_x;
        r.point_y = it.seed_y;
        r.cell_index = idx[14:0];
      end
    end else if (int'(it.slot) >= active_total) begin
      r.status = ST_BAD_SLOT;
    end else begin
      a = active_pts[it.slot];
      x = int'(a[15:0]) + int'($signed(it.offset_x));
      y = int'(a[31:16]) + int'($signed(it.offset_y));
      if (map_to_cell(x, y, col, row)) begin
        idx = col + row * eff_cols();
        r.cell_index = idx[14:0];
        if (grid_full[idx]) begin
          r.status = ST_OCCUPIED;
        end else if (near_neighbor(x, y, col, row)) begin
          r.status = ST_CLOSE;
        end else begin
          grid_full[idx] = 1'b1;
          grid_point[idx] = {y[15:0], x[15:0]};
          if (active_total < GRID_CAP) begin
            active_pts[active_total] = grid_point[idx];
            active_total++;
          end
          slot_found = 1'b1;
          r.status = ST_ACCEPT;
          r.point_x = x[15:0];
          r.point_y = y[15:0];
        end
      end
      if (it.last_trial) begin
        // Retire by swap-with-last when the slot produced nothing.
        if (!slot_found) begin
          active_pts[it.slot] = active_pts[active_total - 1];
          active_total--;
          r.retired = 1'b1;
        end
        slot_found = 1'b0;
      end
    end
    r.active_count = active_total[15:0];
    pending_results.insert(pending_results.size(), r);
  endtask

  // Offer one item, hold it until accepted, then predict.
  task automatic send_item(input trial_item_t it);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    func       <= it.func;
    seed_x     <= it.seed_x;
    seed_y     <= it.seed_y;
    slot       <= it.slot;
    offset_x   <= it.offset_x;
    offset_y   <= it.offset_y;
    last_trial <= it.last_trial;
    do @(posedge clk); while (in_stall);
    predict_result(it);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      CFG_MIN_DIST:  min_dist = int'(val[13:0]);
      CFG_CELL_SIZE: cell_sz  = int'(val);
      CFG_COLS:      cols_reg = int'(val[8:0]);
      CFG_ROWS:      rows_reg = int'(val[7:0]);
      default: ;
    endcase
  endtask

  // Pause the sender until every result is back, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic configure(input int md, input int cs, input int c, input int r);
    drain();
    write_reg(CFG_MIN_DIST, md[15:0]);
    write_reg(CFG_CELL_SIZE, cs[15:0]);
    write_reg(CFG_COLS, c[15:0]);
    write_reg(CFG_ROWS, r[15:0]);
  endtask

  function automatic trial_item_t seed_item(input int x, input int y);
    trial_item_t it;
    it.func = FUNC_SEED;
    it.seed_x = x[15:0];
    it.seed_y = y[15:0];
    it.slot = 15'($urandom);
    it.offset_x = 15'($urandom);
    it.offset_y = 15'($urandom);
    it.last_trial = 1'($urandom);
    return it;
  endfunction

  function automatic trial_item_t trial(input int s, input int dx, input int dy,
                                        input bit last);
    trial_item_t it;
    it.func = FUNC_TRIAL;
    it.seed_x = 16'($urandom);
    it.seed_y = 16'($urandom);
    it.slot = s[14:0];
    it.offset_x = dx[14:0];
    it.offset_y = dy[14:0];
    it.last_trial = last;
    return it;
  endfunction

  // Seed somewhere inside the grid in use.
  task automatic send_random_seed();
    int cs, xmax, ymax;
    cs = cell_sz == 0 ? 1 : cell_sz;
    xmax = eff_cols() * cs - 1;
    ymax = eff_rows() * cs - 1;
    if (xmax > 65535) xmax = 65535;
    if (ymax > 65535) ymax = 65535;
    seeds_sent++;
    send_item(seed_item($urandom_range(0, xmax), $urandom_range(0, ymax)));
  endtask

  // Mostly well-formed trials in a square around an active point, some noise.
  task automatic random_trials(input int count);
    int span, dx, dy;
    for (int n = 0; n < count; n++) begin
      if (active_total == 0) begin
        if (seeds_sent < 14) send_random_seed();
        else send_item(trial($urandom, $urandom, $urandom, 1'($urandom)));
        continue;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(trial($urandom, $urandom, $urandom, 1'($urandom)));
      end else begin
        span = 2 * min_dist + 1;
        if (span > 16383) span = 16383;
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
        send_item(trial($urandom_range(0, active_total - 1), dx, dy,
                        $urandom_range(0, 5) == 0));
      end
    end
  endtask

  task automatic test_directed();
    tx_gaps = 0;
    rx_gaps = 0;
    // Seed outside the grid leaves it cleared; any trial then has a bad slot.
    send_item(seed_item(65535, 65535));
    send_item(trial(0, 0, 0, 1));
    seeds_sent++;
    send_item(seed_item(1000, 1000));
    send_item(trial(0, 0, 0, 0));          // same cell
    send_item(trial(0, 250, 0, 0));        // neighbor cell, too close
    send_item(trial(0, 320, 0, 0));        // exactly at minimum distance
    send_item(trial(0, 400, 0, 0));        // accepted
    send_item(trial(0, -16384, 0, 0));     // negative coordinate
    send_item(trial(0, 0, -16384, 1));     // off plane, slot had an accept
    send_item(trial(0, 16383, 16383, 0));
    send_item(trial(1, 0, 0, 1));          // retire with nothing found
    send_item(trial(32767, 0, 0, 0));      // bad slot
    send_item(trial(0, 16383, 0, 0));
    send_item(trial(0, 16383, 16383, 0));
    send_item(trial(0, -500, -500, 1));
    send_item(trial(active_total, 1, 1, 1));
    send_item(seed_item(0, 0));
    send_item(trial(0, 65, 0, 0));
    send_item(trial(0, 0, 0, 1));
  endtask

  task automatic test_default_grid();
    tx_gaps = 1;
    rx_gaps = 1;
    send_random_seed();
    random_trials(650);
  endtask

  // Keep the receiver off while the sender keeps offering.
  task automatic test_backpressure();
    hold_req = 1'b1;
    random_trials(30);
    drain();
  endtask

  task automatic test_tiny_grid();
    configure(320, 226, 4, 3);
    send_random_seed();
    random_trials(150);
  endtask

  task automatic test_single_cell_extremes();
    configure(16383, 65535, 256, 128);
    send_random_seed();
    random_trials(60);
    // Largest grid with small cells reaches the top cell indexes.
    configure(20, 16, 256, 128);
    send_item(seed_item(4095, 2047));
    random_trials(100);
  endtask

  task automatic test_clamped_geometry();
    configure(1, 0, 0, 0);
    send_item(seed_item(0, 0));
    random_trials(40);
    configure(40, 300, 511, 255);
    send_random_seed();
    random_trials(470);
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = 600;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    disc_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation pending");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status); mismatches++;
        end
        if (point_x !== e.point_x) begin
          $error("point_x expected %0d actual %0d", e.point_x, point_x); mismatches++;
        end
        if (point_y !== e.point_y) begin
          $error("point_y expected %0d actual %0d", e.point_y, point_y); mismatches++;
        end
        if (cell_index !== e.cell_index) begin
          $error("cell_index expected %0d actual %0d", e.cell_index, cell_index);
          mismatches++;
        end
        if (active_count !== e.active_count) begin
          $error("active_count expected %0d actual %0d", e.active_count, active_count);
          mismatches++;
        end
        if (retired !== e.retired) begin
          $error("retired expected %0d actual %0d", e.retired, retired); mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving on either channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0; wr_index = '0; wr_data = '0;
    in_valid = 1'b0; func = FUNC_SEED;
    seed_x = '0; seed_y = '0; slot = '0;
    offset_x = '0; offset_y = '0; last_trial = 1'b0;
    mismatches = 0; seeds_sent = 0; hold_req = 1'b0;
    tx_gaps = 0; rx_gaps = 0;
    min_dist = 320; cell_sz = 226; cols_reg = 135; rows_reg = 76;
    active_total = 0; slot_found = 1'b0;
    foreach (grid_full[i]) grid_full[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_default_grid();
    test_backpressure();
    test_tiny_grid();
    test_single_cell_extremes();
    test_clamped_geometry();
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
